### design/nonuniform_three_point_derivative_assert.svh
// Assertion macros shared by the derivative block.
// They sample on clk_i and are disabled while rst_ni is low.
`ifndef NONUNIFORM_THREE_POINT_DERIVATIVE_ASSERT_SVH
`define NONUNIFORM_THREE_POINT_DERIVATIVE_ASSERT_SVH

// Condition that must hold at every clock edge.
`define NUTPD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define NUTPD_ASSERT_IMPL(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NUTPD_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

### design/nutpd_pkg.sv
`timescale 1ns / 1ps

package nutpd_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Which slopes were used for a result.
  typedef enum logic [1:0] {
    CASE_AVG    = 2'd0,
    CASE_FWD    = 2'd1,
    CASE_BWD    = 2'd2,
    CASE_REPEAT = 2'd3
  } slope_case_e;

  // Status of one slope unit toward the controller.
  typedef struct packed {
    logic done;
    logic sat;
  } slope_status_t;

endpackage

### design/nonuniform_three_point_derivative.sv
`timescale 1ns / 1ps
// Three-point derivative over a stream of (x, y) samples with uneven spacing.
// Input channel: x_value_i, y_value_i, last_sample_i with in_valid_i and
// in_stall_o; a transaction completes when valid is high and stall is low.
// Output channel: x_center_o, slope_o, slope_case_o, saturated_o,
// end_of_set_o with out_valid_o and out_stall_i.
// The first two samples of a set only fill the history. Every later sample
// produces one result for the middle point; both one-sided slopes are
// computed in parallel by two restoring dividers that retire one quotient
// bit per cycle. The input stays stalled until the result of such a sample
// has been moved into the output register.
// The output register holds a result while out_stall_i is high; the block
// then accepts the next sample and can work on it, but a second result
// waits inside until the output register is free.
// After the sample flagged last, the history and the repeated slope are
// cleared so the next transaction starts a new set. Reset puts the block in
// the same empty state with no result pending.
module nonuniform_three_point_derivative #(
  parameter int DATA_WIDTH = nutpd_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = nutpd_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] x_value_i,
  input  logic signed [DATA_WIDTH-1:0] y_value_i,
  input  logic                         last_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] x_center_o,
  output logic signed [DATA_WIDTH-1:0] slope_o,
  output logic [1:0]                   slope_case_o,
  output logic                         saturated_o,
  output logic                         end_of_set_o
);

`include "nonuniform_three_point_derivative_assert.svh"

  localparam int W = DATA_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WAIT = 3'b010,
    S_COMB = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic [1:0]   seen_q, seen_d;
  logic [W-1:0] last_slope_q, last_slope_d;
  logic         start_q, start_d;
  logic [W-1:0] older_x_q, older_x_d, older_y_q, older_y_d;
  logic [W-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [W-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic         cur_last_q, cur_last_d;

  logic         out_valid_q, out_valid_d;
  logic [W-1:0] x_center_q, x_center_d, slope_q, slope_d;
  nutpd_pkg::slope_case_e case_q, case_d;
  logic         sat_q, sat_d, eos_q, eos_d;

  logic signed [W-1:0]      fwd_slope, bwd_slope;
  nutpd_pkg::slope_status_t fwd_st, bwd_st;

  logic         in_acc, out_free, out_load;
  logic         right_ok, left_ok;
  logic [W:0]   avg_sum;
  logic [W-1:0] res_slope;
  logic         res_sat;
  nutpd_pkg::slope_case_e res_case;

  nutpd_slope #(.W(W), .F(FRAC_BITS)) u_fwd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .xa_i     (prev_x_q),
    .ya_i     (prev_y_q),
    .xb_i     (cur_x_q),
    .yb_i     (cur_y_q),
    .slope_o  (fwd_slope),
    .status_o (fwd_st)
  );

  nutpd_slope #(.W(W), .F(FRAC_BITS)) u_bwd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .xa_i     (older_x_q),
    .ya_i     (older_y_q),
    .xb_i     (prev_x_q),
    .yb_i     (prev_y_q),
    .slope_o  (bwd_slope),
    .status_o (bwd_st)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_COMB) && out_free;

  // Pick the slope source from which spacings are nonzero.
  always_comb begin
    right_ok = (cur_x_q != prev_x_q);
    left_ok  = (older_x_q != prev_x_q);
    avg_sum  = {fwd_slope[W-1], fwd_slope} + {bwd_slope[W-1], bwd_slope};
    priority if (right_ok && left_ok) begin
      res_slope = avg_sum[W:1];
      res_sat   = fwd_st.sat | bwd_st.sat;
      res_case  = nutpd_pkg::CASE_AVG;
    end else if (right_ok) begin
      res_slope = fwd_slope;
      res_sat   = fwd_st.sat;
      res_case  = nutpd_pkg::CASE_FWD;
    end else if (left_ok) begin
      res_slope = bwd_slope;
      res_sat   = bwd_st.sat;
      res_case  = nutpd_pkg::CASE_BWD;
    end else begin
      res_slope = last_slope_q;
      res_sat   = 1'b0;
      res_case  = nutpd_pkg::CASE_REPEAT;
    end
  end

  always_comb begin
    state_d      = state_q;
    seen_d       = seen_q;
    last_slope_d = last_slope_q;
    start_d      = 1'b0;
    older_x_d    = older_x_q;
    older_y_d    = older_y_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    cur_last_d   = cur_last_q;
    out_valid_d  = out_valid_q && out_stall_i;
    x_center_d   = x_center_q;
    slope_d      = slope_q;
    case_d       = case_q;
    sat_d        = sat_q;
    eos_d        = eos_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (seen_q == 2'd2) begin
            cur_x_d    = x_value_i;
            cur_y_d    = y_value_i;
            cur_last_d = last_sample_i;
            start_d    = 1'b1;
            state_d    = S_WAIT;
          end else begin
            older_x_d = prev_x_q;
            older_y_d = prev_y_q;
            prev_x_d  = x_value_i;
            prev_y_d  = y_value_i;
            seen_d    = last_sample_i ? 2'd0 : seen_q + 2'd1;
            if (last_sample_i) begin
              last_slope_d = '0;
            end
          end
        end
      end
      S_WAIT: begin
        if (fwd_st.done) begin
          state_d = S_COMB;
        end
      end
      S_COMB: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          x_center_d   = prev_x_q;
          slope_d      = res_slope;
          case_d       = res_case;
          sat_d        = res_sat;
          eos_d        = cur_last_q;
          older_x_d    = prev_x_q;
          older_y_d    = prev_y_q;
          prev_x_d     = cur_x_q;
          prev_y_d     = cur_y_q;
          last_slope_d = cur_last_q ? '0 : res_slope;
          seen_d       = cur_last_q ? 2'd0 : 2'd2;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      seen_q       <= 2'd0;
      last_slope_q <= '0;
      start_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      seen_q       <= seen_d;
      last_slope_q <= last_slope_d;
      start_q      <= start_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    older_x_q  <= older_x_d;
    older_y_q  <= older_y_d;
    prev_x_q   <= prev_x_d;
    prev_y_q   <= prev_y_d;
    cur_x_q    <= cur_x_d;
    cur_y_q    <= cur_y_d;
    cur_last_q <= cur_last_d;
    x_center_q <= x_center_d;
    slope_q    <= slope_d;
    case_q     <= case_d;
    sat_q      <= sat_d;
    eos_q      <= eos_d;
  end

  assign out_valid_o  = out_valid_q;
  assign x_center_o   = x_center_q;
  assign slope_o      = slope_q;
  assign slope_case_o = case_q;
  assign saturated_o  = sat_q;
  assign end_of_set_o = eos_q;

  `NUTPD_ASSERT_ALWAYS(a_units_lockstep, fwd_st.done == bwd_st.done,
    "slope units finished in different cycles")
  `NUTPD_ASSERT_IMPL(a_done_in_wait, fwd_st.done, state_q == S_WAIT,
    "slope unit finished while the controller was not waiting")
  `NUTPD_ASSERT_NEXT(a_short_set_clear, in_acc && last_sample_i && (seen_q != 2'd2),
    (seen_q == 2'd0) && (last_slope_q == '0), "short set did not clear the history")
  `NUTPD_ASSERT_IMPL(a_repeat_unsat, out_load && (res_case == nutpd_pkg::CASE_REPEAT),
    !res_sat, "repeated slope flagged as saturated")

endmodule

### design/nutpd_slope.sv
`timescale 1ns / 1ps

// One-sided slope (yb - ya) * 2^F / (xb - xa), truncated toward zero and
// saturated. The quotient is produced one bit per cycle by a restoring
// divider; the dividend magnitude is shifted in MSB first, then F zeros.
module nutpd_slope #(
  parameter int W = nutpd_pkg::DATA_WIDTH_DEF,
  parameter int F = nutpd_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [W-1:0]      xa_i,
  input  logic signed [W-1:0]      ya_i,
  input  logic signed [W-1:0]      xb_i,
  input  logic signed [W-1:0]      yb_i,
  output logic signed [W-1:0]      slope_o,
  output nutpd_pkg::slope_status_t status_o
);

  localparam int STEPS = W + F;
  localparam int CW    = $clog2(STEPS + 1);
  localparam logic [W:0]   HALF    = (W + 1)'(1) << (W - 1);
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W - 1){1'b0}}};

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_ABS  = 4'b0010,
    U_ITER = 4'b0100,
    U_FIN  = 4'b1000
  } unit_state_e;

  unit_state_e state_q, state_d;
  logic [W:0]    dy_q, dy_d, dx_q, dx_d;
  logic [W-1:0]  num_q, num_d, den_q, den_d, rem_q, rem_d;
  logic [W:0]    quo_q, quo_d;
  logic          big_q, big_d, neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  slope_q, slope_d;
  logic          sat_q, sat_d, done_q, done_d;

  logic [W:0] dy_neg, dx_neg, rem_sh, rem_sub;
  logic       in_bit, ge;

  always_comb begin
    dy_neg  = ~dy_q + (W + 1)'(1);
    dx_neg  = ~dx_q + (W + 1)'(1);
    in_bit  = (cnt_q < CW'(W)) ? num_q[W-1] : 1'b0;
    rem_sh  = {rem_q, in_bit};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_comb begin
    state_d = state_q;
    dy_d    = dy_q;
    dx_d    = dx_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    big_d   = big_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    slope_d = slope_q;
    sat_d   = sat_q;
    done_d  = 1'b0;
    unique case (state_q)
      U_IDLE: begin
        if (start_i) begin
          dy_d    = {yb_i[W-1], yb_i} - {ya_i[W-1], ya_i};
          dx_d    = {xb_i[W-1], xb_i} - {xa_i[W-1], xa_i};
          state_d = U_ABS;
        end
      end
      U_ABS: begin
        num_d   = dy_q[W] ? dy_neg[W-1:0] : dy_q[W-1:0];
        den_d   = dx_q[W] ? dx_neg[W-1:0] : dx_q[W-1:0];
        neg_d   = dy_q[W] ^ dx_q[W];
        rem_d   = '0;
        quo_d   = '0;
        big_d   = 1'b0;
        cnt_d   = '0;
        state_d = U_ITER;
      end
      U_ITER: begin
        rem_d = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
        // A quotient bit pushed past the top means the result is far out of range.
        big_d = big_q | quo_q[W];
        quo_d = {quo_q[W-1:0], ge};
        num_d = {num_q[W-2:0], 1'b0};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(STEPS - 1)) begin
          state_d = U_FIN;
        end
      end
      U_FIN: begin
        if (neg_q) begin
          sat_d   = big_q || (quo_q > HALF);
          slope_d = sat_d ? MIN_NEG : ~quo_q[W-1:0] + W'(1);
        end else begin
          sat_d   = big_q || (quo_q >= HALF);
          slope_d = sat_d ? MAX_POS : quo_q[W-1:0];
        end
        done_d  = 1'b1;
        state_d = U_IDLE;
      end
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dy_q    <= dy_d;
    dx_q    <= dx_d;
    num_q   <= num_d;
    den_q   <= den_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    big_q   <= big_d;
    neg_q   <= neg_d;
    cnt_q   <= cnt_d;
    slope_q <= slope_d;
    sat_q   <= sat_d;
  end

  assign slope_o       = slope_q;
  assign status_o.done = done_q;
  assign status_o.sat  = sat_q;

endmodule
